// File: rtl/core/k_strongest_per_row_filter_core_macros.svh
// ----------------------------------------------------------------------------
// K-strongest filter assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef K_STRONGEST_PER_ROW_FILTER_CORE_MACROS_SVH
`define K_STRONGEST_PER_ROW_FILTER_CORE_MACROS_SVH

// expression holds at every clock edge
`define KSF_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("ksf assertion failed");

// consequent holds in the same cycle as the antecedent
`define KSF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ksf assertion failed");

// consequent holds in the cycle after the antecedent
`define KSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ksf assertion failed");

`endif

// File: rtl/core/ksf_pkg.sv
// ----------------------------------------------------------------------------
// K-strongest filter package
// Sizes, register indexes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package ksf_pkg;

    localparam int MAX_KEEP  = 16;
    localparam int ROW_BINS  = 4096;
    localparam int KEEP_IW   = $clog2(MAX_KEEP);
    localparam int KEEP_CW   = $clog2(MAX_KEEP + 1);
    localparam int BIN_W     = $clog2(ROW_BINS);
    localparam int POW_W     = 8;
    localparam int AZ_W      = 16;
    localparam int KCFG_W    = 5;

    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 40;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEEP_COUNT      = 1'b0,
        REG_POWER_THRESHOLD = 1'b1
    } ksf_reg_t;

    typedef struct packed {
        logic take;
        logic append;
        logic scan_init;
        logic scan_step;
        logic scan_emit;
        logic replace;
        logic emit_load;
        logic clear;
    } ksf_cmd_t;

    typedef struct packed {
        logic k_zero;
        logic room;
        logic min_end;
        logic emit_end;
        logic pend_none;
        logic out_free;
        logic row_last;
    } ksf_sts_t;

endpackage

// File: rtl/core/ksf_ctrl.sv
// ----------------------------------------------------------------------------
// K-strongest filter controller
// Sequences insertion, weakest-entry scan, replacement and row emission.
// ----------------------------------------------------------------------------
module ksf_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ksf_pkg::ksf_sts_t sts,
    output ksf_pkg::ksf_cmd_t cmd
);
    import ksf_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_UPDATE    = 6'b000010,
        ST_SCAN_MIN  = 6'b000100,
        ST_REPLACE   = 6'b001000,
        ST_EMIT_SCAN = 6'b010000,
        ST_EMIT_LOAD = 6'b100000
    } ksf_state_t;

    ksf_state_t state_reg;
    ksf_state_t state_next;
    ksf_state_t done_state;

    assign s_tready   = (state_reg == ST_IDLE);
    assign done_state = sts.row_last ? ST_EMIT_SCAN : ST_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.scan_init = 1'b1;
                if (sts.k_zero)
                begin
                    state_next = done_state;
                end
                else if (sts.room)
                begin
                    cmd.append = 1'b1;
                    state_next = done_state;
                end
                else
                begin
                    state_next = ST_SCAN_MIN;
                end
            end
            ST_SCAN_MIN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.min_end)
                begin
                    state_next = ST_REPLACE;
                end
            end
            ST_REPLACE:
            begin
                cmd.replace   = 1'b1;
                cmd.scan_init = 1'b1;
                state_next    = done_state;
            end
            ST_EMIT_SCAN:
            begin
                if (sts.pend_none)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    cmd.scan_emit = 1'b1;
                    if (sts.emit_end)
                    begin
                        state_next = ST_EMIT_LOAD;
                    end
                end
            end
            ST_EMIT_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    cmd.scan_init = 1'b1;
                    state_next    = ST_EMIT_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/ksf_datapath.sv
// ----------------------------------------------------------------------------
// K-strongest filter datapath
// Kept-entry store, bin counter, serial weakest search and output register.
// ----------------------------------------------------------------------------
`include "k_strongest_per_row_filter_core_macros.svh"

module ksf_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  ksf_pkg::ksf_cmd_t                   cmd,
    output ksf_pkg::ksf_sts_t                   sts,
    input  logic [ksf_pkg::S_DATA_W-1:0]        s_tdata,
    input  logic                                s_tlast,
    input  logic                                cfg_valid,
    input  logic [ksf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ksf_pkg::CFG_DAT_W-1:0]       cfg_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ksf_pkg::M_DATA_W-1:0]        m_tdata,
    output logic                                m_tlast
);
    import ksf_pkg::*;

    logic [BIN_W-1:0]   kbin_reg [MAX_KEEP];
    logic [POW_W-1:0]   kpow_reg [MAX_KEEP];
    logic [KEEP_CW-1:0] count_reg;
    logic [MAX_KEEP-1:0] done_reg;
    logic [BIN_W-1:0]   bin_cnt_reg;

    logic [POW_W-1:0]   smp_pow_reg;
    logic [BIN_W-1:0]   smp_bin_reg;
    logic [AZ_W-1:0]    az_reg;
    logic               last_reg;

    logic [KEEP_IW-1:0] idx_reg;
    logic [KEEP_IW-1:0] best_idx_reg;
    logic [POW_W-1:0]   best_pow_reg;
    logic [BIN_W-1:0]   best_bin_reg;
    logic               best_vld_reg;

    logic               out_valid_reg;
    logic [BIN_W-1:0]   out_bin_reg;
    logic [POW_W-1:0]   out_pow_reg;
    logic [AZ_W-1:0]    out_az_reg;
    logic               out_last_reg;

    logic [KCFG_W-1:0]  keep_count_reg;
    logic [POW_W-1:0]   thr_reg;

    logic [KCFG_W-1:0]   k_eff;
    logic [MAX_KEEP-1:0] qual;
    logic [MAX_KEEP-1:0] pending;
    logic                pend_single;
    logic [POW_W-1:0]    cur_pow;
    logic [BIN_W-1:0]    cur_bin;
    logic                weaker;
    logic                consider;
    logic                out_free;

    assign k_eff = (keep_count_reg > KCFG_W'(MAX_KEEP)) ? KCFG_W'(MAX_KEEP) : keep_count_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_KEEP; i++)
        begin
            qual[i] = (KEEP_CW'(i) < count_reg) && (kpow_reg[i] > thr_reg);
        end
    end

    assign pending     = qual & ~done_reg;
    assign pend_single = ((pending & (pending - MAX_KEEP'(1))) == '0);

    assign cur_pow  = kpow_reg[idx_reg];
    assign cur_bin  = kbin_reg[idx_reg];
    assign weaker   = (cur_pow < best_pow_reg)
                   || ((cur_pow == best_pow_reg) && (cur_bin > best_bin_reg));
    assign consider = !cmd.scan_emit || pending[idx_reg];
    assign out_free = !out_valid_reg || m_tready;

    assign sts.k_zero    = (k_eff == '0);
    assign sts.room      = (KCFG_W'(count_reg) < k_eff);
    assign sts.min_end   = ((KEEP_CW'(idx_reg) + KEEP_CW'(1)) == count_reg);
    assign sts.emit_end  = (idx_reg == KEEP_IW'(MAX_KEEP - 1));
    assign sts.pend_none = (pending == '0);
    assign sts.out_free  = out_free;
    assign sts.row_last  = last_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_DATA_W - AZ_W - POW_W - BIN_W)'(0), out_az_reg, out_pow_reg, out_bin_reg};
    assign m_tlast  = out_last_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= KCFG_W'(12);
            thr_reg        <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_KEEP_COUNT:      keep_count_reg <= cfg_data[KCFG_W-1:0];
                REG_POWER_THRESHOLD: thr_reg        <= cfg_data[POW_W-1:0];
                default:             ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            done_reg      <= '0;
            bin_cnt_reg   <= '0;
            idx_reg       <= '0;
            best_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                bin_cnt_reg <= s_tlast ? '0 : bin_cnt_reg + BIN_W'(1);
            end
            if (cmd.append)
            begin
                count_reg <= count_reg + KEEP_CW'(1);
            end
            if (cmd.scan_init)
            begin
                idx_reg      <= '0;
                best_vld_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + KEEP_IW'(1);
                if (consider && (!best_vld_reg || weaker))
                begin
                    best_vld_reg <= 1'b1;
                end
            end
            if (cmd.emit_load)
            begin
                done_reg[best_idx_reg] <= 1'b1;
            end
            if (cmd.clear)
            begin
                count_reg <= '0;
                done_reg  <= '0;
            end
            if (cmd.emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            smp_pow_reg <= s_tdata[POW_W-1:0];
            az_reg      <= s_tdata[POW_W +: AZ_W];
            smp_bin_reg <= bin_cnt_reg;
            last_reg    <= s_tlast;
        end
        if (cmd.append)
        begin
            kpow_reg[count_reg[KEEP_IW-1:0]] <= smp_pow_reg;
            kbin_reg[count_reg[KEEP_IW-1:0]] <= smp_bin_reg;
        end
        if (cmd.replace && (smp_pow_reg > best_pow_reg))
        begin
            kpow_reg[best_idx_reg] <= smp_pow_reg;
            kbin_reg[best_idx_reg] <= smp_bin_reg;
        end
        if (cmd.scan_step && consider && (!best_vld_reg || weaker))
        begin
            best_idx_reg <= idx_reg;
            best_pow_reg <= cur_pow;
            best_bin_reg <= cur_bin;
        end
        if (cmd.emit_load)
        begin
            out_bin_reg  <= best_bin_reg;
            out_pow_reg  <= best_pow_reg;
            out_az_reg   <= az_reg;
            out_last_reg <= pend_single;
        end
    end

    `KSF_ASSERT_ALWAYS(a_count_bound, count_reg <= KEEP_CW'(MAX_KEEP))
    `KSF_ASSERT_NEXT(a_clear_empties, cmd.clear, (count_reg == '0) && (done_reg == '0))
    `KSF_ASSERT_SAME(a_load_when_free, cmd.emit_load, out_free && best_vld_reg)

endmodule

// File: rtl/core/k_strongest_per_row_filter_core.sv
// ----------------------------------------------------------------------------
// K-strongest per-row filter
// Keeps the strongest range-bin samples of each azimuth row and emits those above the power threshold.
// ----------------------------------------------------------------------------
// One sample is taken per transaction and the block accepts nothing else until
// it is done with it. While the store has room a sample is appended directly;
// once the store is full the weakest entry is found by a scan that reads one
// store entry per cycle, and it is replaced if the sample is stronger. At a row
// end each emitted result takes a full scan of the store for the next weakest
// qualifying entry, then the output load, which waits for a free output register;
// the store is then cleared. The last result of a row may still wait in the
// output register while the next row's first sample is taken.
module k_strongest_per_row_filter_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    // s_tdata: sample_power[7:0], azimuth_code[23:8]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ksf_pkg::S_DATA_W-1:0]       s_tdata,
    input  logic                               s_tlast,
    // m_tdata: bin_index[11:0], strong_power[19:12], row_azimuth[35:20], zero pad
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ksf_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ksf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ksf_pkg::CFG_DAT_W-1:0]      cfg_data
);
    import ksf_pkg::*;

    ksf_cmd_t cmd;
    ksf_sts_t sts;

    assign cfg_ready = 1'b1;

    ksf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ksf_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
